### hw/rtl/integer_divide_remainder_64_macros.svh
// ----------------------------------------------------------------------------
// integer_divide_remainder_64 assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_DIVIDE_REMAINDER_64_MACROS_SVH
`define INTEGER_DIVIDE_REMAINDER_64_MACROS_SVH

// same-cycle implication
`define IDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/idr_pkg.sv
// ----------------------------------------------------------------------------
// idr_pkg
// Opcodes, bus widths and controller/datapath handshake types of the divider.
// ----------------------------------------------------------------------------
package idr_pkg;

  localparam int unsigned XLEN     = 64;
  localparam int unsigned OPCODE_W = 2;

  localparam logic [OPCODE_W-1:0] OP_SDIV = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SREM = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_UDIV = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UREM = 2'd3;

  typedef struct packed {
    logic load;    // capture operands and take magnitudes
    logic triple;  // form 3*divisor, arm the iteration counter
    logic step;    // one radix-4 digit
    logic finish;  // fix sign, write output register
  } idr_cmd_t;

  typedef struct packed {
    logic last_step;
  } idr_sts_t;

endpackage

### hw/rtl/idr_in_if.sv
// ----------------------------------------------------------------------------
// idr_in_if
// Request channel: opcode and two operands with valid/ready.
// ----------------------------------------------------------------------------
interface idr_in_if;
  import idr_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [XLEN-1:0]     dividend;
  logic [XLEN-1:0]     divisor;

  modport source (output valid, output opcode, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input opcode, input dividend, input divisor,
                  output ready);
endinterface

### hw/rtl/idr_out_if.sv
// ----------------------------------------------------------------------------
// idr_out_if
// Response channel: result word and divide-by-zero flag with valid/ready.
// ----------------------------------------------------------------------------
interface idr_out_if;
  import idr_pkg::*;

  logic            valid;
  logic            ready;
  logic [XLEN-1:0] result;
  logic            divide_by_zero;

  modport source (output valid, output result, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input result, input divide_by_zero,
                  output ready);
endinterface

### hw/rtl/idr_dpath.sv
// ----------------------------------------------------------------------------
// idr_dpath
// Divider datapath: operand magnitudes, radix-4 digit loop, sign fix-up.
// ----------------------------------------------------------------------------
module idr_dpath #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                         clk_i,
  input  idr_pkg::idr_cmd_t            cmd_i,
  output idr_pkg::idr_sts_t            sts_o,
  input  logic [idr_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [idr_pkg::XLEN-1:0]     dividend_i,
  input  logic [idr_pkg::XLEN-1:0]     divisor_i,
  output logic [idr_pkg::XLEN-1:0]     result_o,
  output logic                         divide_by_zero_o
);
  import idr_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned QW   = W + (W % 2);   // dividend padded to whole digits
  localparam int unsigned ITER = QW / 2;
  localparam int unsigned CW   = $clog2(ITER);
  localparam int unsigned RW   = W + 2;

  logic [OPCODE_W-1:0] op_q;
  logic [QW-1:0]       q_q;
  logic [W-1:0]        r_q;
  logic [W-1:0]        d_q;
  logic [RW-1:0]       d3_q;
  logic [CW-1:0]       cnt_q;
  logic                neg_q_q, neg_r_q;
  logic [XLEN-1:0]     result_q;
  logic                dbz_q;

  logic [W-1:0] a_w, b_w, a_mag, b_mag;
  logic         sgn_op, a_neg, b_neg;

  assign a_w    = dividend_i[W-1:0];
  assign b_w    = divisor_i[W-1:0];
  assign sgn_op = ~opcode_i[1];
  assign a_neg  = sgn_op & a_w[W-1];
  assign b_neg  = sgn_op & b_w[W-1];
  assign a_mag  = a_neg ? (W'(0) - a_w) : a_w;
  assign b_mag  = b_neg ? (W'(0) - b_w) : b_w;

  // digit selection against d, 2d, 3d
  logic [RW-1:0] r4, d1, d2;
  logic [RW:0]   s1, s2, s3;
  logic [1:0]    digit;
  logic [W-1:0]  r_next;

  assign r4 = {r_q, q_q[QW-1 -: 2]};
  assign d1 = RW'(d_q);
  assign d2 = {1'b0, d_q, 1'b0};
  assign s1 = {1'b0, r4} - {1'b0, d1};
  assign s2 = {1'b0, r4} - {1'b0, d2};
  assign s3 = {1'b0, r4} - {1'b0, d3_q};

  always_comb begin
    if (!s3[RW]) begin
      digit  = 2'd3;
      r_next = s3[W-1:0];
    end else if (!s2[RW]) begin
      digit  = 2'd2;
      r_next = s2[W-1:0];
    end else if (!s1[RW]) begin
      digit  = 2'd1;
      r_next = s1[W-1:0];
    end else begin
      digit  = 2'd0;
      r_next = r4[W-1:0];
    end
  end

  // result selection and sign fix-up
  logic [W-1:0] res_mag, res_w;
  logic         res_neg, is_rem;

  assign is_rem  = (op_q == OP_SREM) || (op_q == OP_UREM);
  assign res_mag = is_rem ? r_q : q_q[W-1:0];
  assign res_neg = is_rem ? neg_r_q : neg_q_q;
  assign res_w   = res_neg ? (W'(0) - res_mag) : res_mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      q_q     <= QW'(a_mag);
      d_q     <= b_mag;
      r_q     <= '0;
      neg_q_q <= a_neg ^ b_neg;
      neg_r_q <= a_neg;
    end
    if (cmd_i.triple) begin
      d3_q  <= RW'(d_q) + {1'b0, d_q, 1'b0};
      cnt_q <= CW'(ITER - 1);
      dbz_q <= (d_q == '0);
    end
    if (cmd_i.step) begin
      q_q   <= {q_q[QW-3:0], digit};
      r_q   <= r_next;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.finish) begin
      result_q         <= dbz_q ? '0 : XLEN'(res_w);
      divide_by_zero_o <= dbz_q;
    end
  end

  assign sts_o.last_step = (cnt_q == '0);
  assign result_o        = result_q;

endmodule

### hw/rtl/idr_ctrl.sv
// ----------------------------------------------------------------------------
// idr_ctrl
// Divider sequencer: accept, prepare, iterate, fix-up, hold output beat.
// ----------------------------------------------------------------------------
`include "integer_divide_remainder_64_macros.svh"

module idr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output idr_pkg::idr_cmd_t cmd_o,
  input  idr_pkg::idr_sts_t sts_i
);
  import idr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TRIPLE = 2'd1;
  localparam logic [1:0] S_ITER   = 2'd2;
  localparam logic [1:0] S_FIX    = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TRIPLE;
        end
      end
      S_TRIPLE: begin
        cmd_o.triple = 1'b1;
        state_d      = S_ITER;
      end
      S_ITER: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output beat stays until taken
  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `IDR_ASSERT_NEXT(a_accept_to_triple, in_valid_i && in_ready_o, state_q == S_TRIPLE, "accepted beat did not start preparation")
  `IDR_ASSERT_NEXT(a_last_to_fix, cmd_o.step && sts_i.last_step, state_q == S_FIX, "last digit did not lead to fix-up")
  `IDR_ASSERT_SAME(a_finish_free, cmd_o.finish, !out_valid_q || out_ready_i, "output register overwritten before taken")
  `IDR_ASSERT_NEXT(a_finish_valid, cmd_o.finish, out_valid_o && in_ready_o, "finished result not presented")

endmodule

### hw/rtl/integer_divide_remainder_64.sv
// Sequence: an accepted beat passes through preparation (S_TRIPLE), the radix-4 loop
//   (S_ITER, retiring two bits a cycle) and fix-up (S_FIX) before a valid result appears.
// Overlap: the next beat is taken while the previous result still waits in the
//   output register; no new beat is taken while a division is in progress.
// Reset: rst_ni asynchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// integer_divide_remainder_64
// Signed/unsigned 64-bit divide and remainder with divide-by-zero flag.
// ----------------------------------------------------------------------------
module integer_divide_remainder_64 #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idr_in_if.sink     in_i,
  idr_out_if.source  out_o
);
  import idr_pkg::*;

  idr_cmd_t cmd;
  idr_sts_t sts;

  idr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  idr_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (in_i.opcode),
    .dividend_i       (in_i.dividend),
    .divisor_i        (in_i.divisor),
    .result_o         (out_o.result),
    .divide_by_zero_o (out_o.divide_by_zero)
  );

endmodule
